### rtl/pdp_pkg.sv
// shared types and codes for the page dedup placement planner
// no dependencies; imported by pdp_front, pdp_back and the top level
`default_nettype none

package pdp_pkg;

  localparam int CANON_W = 10;
  localparam int SLOT_W  = 16;
  localparam int TOTAL_W = 11;

  // placement kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FAST  = 2'd1;
  localparam logic [1:0] KIND_FLASH = 2'd2;

  // plan status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MAP  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_FAST_CAP  = 2'd0;
  localparam logic [1:0] REG_FLASH_CAP = 2'd1;
  localparam logic [1:0] REG_FLASH_EN  = 2'd2;

  // classification made by the front part
  typedef struct packed {
    logic last;
    logic bad;
    logic self_page;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  // one entry of the per-page placement table
  typedef struct packed {
    logic              self_page;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] unique_total;
    logic [TOTAL_W-1:0] duplicate_total;
    logic [TOTAL_W-1:0] fast_total;
    logic [TOTAL_W-1:0] flash_total;
    logic               done;
  } res_t;

endpackage

`default_nettype wire

### rtl/pdp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/pdp_front.sv
// front part: accepts pages, keeps the page index and classifies each item
// depends on pdp_pkg
`default_nettype none

module pdp_front #(
  parameter int MAX_PAGES = 1024
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [pdp_pkg::CANON_W-1:0]   canon,
  input  wire                          last,
  input  wire                          q_full,
  output logic                         q_push,
  output logic [2*$clog2(MAX_PAGES)+pdp_pkg::CLS_W-1:0] q_data
);
  import pdp_pkg::*;

  localparam int IW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int XW = CW + CANON_W;
  localparam logic [CW-1:0] PAGE_MAX = CW'(MAX_PAGES);

  logic [CW-1:0]         page_counter;
  logic [CW-1:0]         page_counter_next;
  logic [XW-1:0]         page_ext;
  logic [XW-1:0]         canon_ext;
  logic [IW+CANON_W-1:0] canon_wide;
  logic [IW-1:0]         canon_idx;
  cls_t                  cls;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign page_ext   = {{CANON_W{1'b0}}, page_counter};
  assign canon_ext  = {{CW{1'b0}}, canon};
  assign canon_wide = {{IW{1'b0}}, canon};
  // only used when the canonical page lies below the page, so it fits the index
  assign canon_idx  = canon_wide[IW-1:0];

  always_comb begin
    cls.last      = last;
    cls.bad       = (page_counter >= PAGE_MAX) || (canon_ext > page_ext);
    cls.self_page = (canon_ext == page_ext);
  end

  assign q_data = {page_counter[IW-1:0], canon_idx, cls};

  always_comb begin
    page_counter_next = page_counter;
    if (last) begin
      page_counter_next = '0;
    end else if (page_counter != PAGE_MAX) begin
      page_counter_next = page_counter + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_counter <= '0;
    end else if (q_push) begin
      page_counter <= page_counter_next;
    end
  end

endmodule

`default_nettype wire

### rtl/pdp_queue.sv
// short register fifo between the front and back parts
// no dependencies
`default_nettype none

module pdp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  data_in,
  output logic             full,
  input  wire              pop,
  output logic             valid,
  output logic [WIDTH-1:0] data_out
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT  = NW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full     = (count == FULL_CNT);
  assign valid    = (count != '0);
  assign data_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/pdp_back.sv
// back part: table lookup, slot allocation, sticky status and result register
// depends on pdp_pkg and pdp_ram
`default_nettype none

module pdp_back #(
  parameter int MAX_PAGES = 1024
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        q_valid,
  input  wire [2*$clog2(MAX_PAGES)+pdp_pkg::CLS_W-1:0] q_data,
  output logic                       q_pop,
  input  wire [pdp_pkg::SLOT_W-1:0]  fast_cap,
  input  wire [pdp_pkg::SLOT_W-1:0]  flash_cap,
  input  wire                        flash_en,
  output logic                       out_valid,
  input  wire                        out_ready,
  output pdp_pkg::res_t              res
);
  import pdp_pkg::*;

  localparam int IW = $clog2(MAX_PAGES);

  // queue head
  logic [IW-1:0] h_page;
  logic [IW-1:0] h_canon;
  cls_t          h_cls;

  // execute stage
  logic          e_valid;
  logic [IW-1:0] e_page;
  logic [IW-1:0] e_canon;
  cls_t          e_cls;
  logic          e_fire;

  // last table write, forwarded to a lookup whose table read was taken as that entry was written
  logic          lw_valid;
  logic [IW-1:0] lw_page;
  ent_t          lw_ent;

  logic [ENT_W-1:0] ram_rdata;
  ent_t             rd_ent;
  ent_t             look;
  ent_t             wr_ent;
  logic             wr_req;
  logic             ram_we;

  logic [SLOT_W-1:0]  fast_used;
  logic [SLOT_W-1:0]  flash_used;
  logic [TOTAL_W-1:0] dup_count;
  logic [1:0]         error_code;
  logic [SLOT_W-1:0]  fast_used_next;
  logic [SLOT_W-1:0]  flash_used_next;
  logic [TOTAL_W-1:0] dup_count_next;
  logic [1:0]         error_code_next;
  logic [1:0]         kind;
  logic [SLOT_W-1:0]  slot;
  res_t               res_next;

  assign {h_page, h_canon, h_cls} = q_data;

  assign e_fire = e_valid && (!out_valid || out_ready);
  assign q_pop  = q_valid && (!e_valid || e_fire);
  assign ram_we = wr_req && e_fire;

  pdp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PAGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e_page),
    .wdata (wr_ent),
    .re    (q_pop),
    .raddr (h_canon),
    .rdata (ram_rdata)
  );

  assign rd_ent = ent_t'(ram_rdata);
  assign look   = (lw_valid && lw_page == e_canon) ? lw_ent : rd_ent;

  always_comb begin
    kind            = KIND_NONE;
    slot            = '0;
    fast_used_next  = fast_used;
    flash_used_next = flash_used;
    dup_count_next  = dup_count;
    error_code_next = error_code;
    wr_req          = 1'b0;
    wr_ent          = '0;
    if (error_code == ST_OK) begin
      if (e_cls.bad) begin
        error_code_next = ST_BAD_MAP;
      end else if (e_cls.self_page) begin
        if (fast_used < fast_cap) begin
          kind           = KIND_FAST;
          slot           = fast_used;
          fast_used_next = fast_used + SLOT_W'(1);
        end else if (flash_en && flash_used < flash_cap) begin
          kind            = KIND_FLASH;
          slot            = flash_used;
          flash_used_next = flash_used + SLOT_W'(1);
        end else begin
          error_code_next = ST_NO_SPACE;
        end
        if (kind != KIND_NONE) begin
          wr_req = 1'b1;
          wr_ent = '{self_page: 1'b1, kind: kind, slot: slot};
        end
      end else begin
        // duplicate must point at a placed self-canonical page
        if (!look.self_page || look.kind == KIND_NONE) begin
          error_code_next = ST_BAD_MAP;
        end else begin
          kind           = look.kind;
          slot           = look.slot;
          dup_count_next = dup_count + TOTAL_W'(1);
          wr_req         = 1'b1;
          wr_ent         = '{self_page: 1'b0, kind: kind, slot: slot};
        end
      end
    end
  end

  always_comb begin
    res_next.kind            = kind;
    res_next.slot            = slot;
    res_next.status          = error_code_next;
    res_next.unique_total    = fast_used_next[TOTAL_W-1:0] + flash_used_next[TOTAL_W-1:0];
    res_next.duplicate_total = dup_count_next;
    res_next.fast_total      = fast_used_next[TOTAL_W-1:0];
    res_next.flash_total     = flash_used_next[TOTAL_W-1:0];
    res_next.done            = e_cls.last;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_page  <= h_page;
      e_canon <= h_canon;
      e_cls   <= h_cls;
    end
    if (e_fire) begin
      res <= res_next;
    end
    if (ram_we) begin
      lw_page <= e_page;
      lw_ent  <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid    <= 1'b0;
      out_valid  <= 1'b0;
      lw_valid   <= 1'b0;
      fast_used  <= '0;
      flash_used <= '0;
      dup_count  <= '0;
      error_code <= ST_OK;
    end else begin
      if (q_pop) begin
        e_valid <= 1'b1;
      end else if (e_fire) begin
        e_valid <= 1'b0;
      end
      if (e_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        lw_valid <= 1'b1;
      end
      if (e_fire) begin
        if (e_cls.last) begin
          fast_used  <= '0;
          flash_used <= '0;
          dup_count  <= '0;
          error_code <= ST_OK;
        end else begin
          fast_used  <= fast_used_next;
          flash_used <= flash_used_next;
          dup_count  <= dup_count_next;
          error_code <= error_code_next;
        end
      end
    end
  end

  a_fail_no_place: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status != ST_OK |-> res.kind == KIND_NONE)
    else $error("placement reported on a failed plan");

  a_plan_clear: assert property (@(posedge clk) disable iff (rst)
    e_fire && e_cls.last |=> fast_used == '0 && flash_used == '0 &&
      dup_count == '0 && error_code == ST_OK)
    else $error("plan state not cleared after last page");

  a_no_write_on_fail: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_OK |-> !ram_we)
    else $error("table written after a failure");

  a_sticky_status: assert property (@(posedge clk) disable iff (rst)
    e_fire && error_code != ST_OK && !e_cls.last |=> error_code == $past(error_code))
    else $error("failure status changed inside a plan");

endmodule

`default_nettype wire

### rtl/page_dedup_placement_planner_top.sv
// top level of the page dedup placement planner: config registers and stream ports
// depends on pdp_pkg, pdp_front, pdp_queue, pdp_back, pdp_ram
//
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       tdata: canonical_index; tlast: last_page
//  m_*       out   m_tvalid / m_tready       tdata: placement and totals; tlast: plan_done
//  apb       in    psel, penable, pready     fast_capacity, flash_capacity, flash_enable
//
// one page per cycle sustained while m_tready stays high; results pass the queue, the execute
// stage and the result register; the rate is set by the placement table: one registered read
// and one write per page, with the entry written on the previous edge forwarded to the lookup
// rst (synchronous) clears the page counter, plan state, queue and config registers
// the table needs no clearing; a stalled m side backs up into the queue, then s_tready
`default_nettype none

module page_dedup_placement_planner_top #(
  parameter int MAX_PAGES = 1024
) (
  input  wire         clk,
  input  wire         rst,
  // canonical_index [9:0], zeros [15:10]
  input  wire  [15:0] s_tdata,
  input  wire         s_tlast,
  input  wire         s_tvalid,
  output logic        s_tready,
  // page_kind [1:0], page_slot [17:2], plan_status [19:18], unique_total [30:20],
  // duplicate_total [41:31], fast_total [52:42], flash_total [63:53]
  output logic [63:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pdp_pkg::*;

  localparam int IW = $clog2(MAX_PAGES);
  localparam int QW = 2 * IW + CLS_W;
  localparam int QUEUE_DEPTH = 4;

  logic [SLOT_W-1:0] fast_capacity;
  logic [SLOT_W-1:0] flash_capacity;
  logic              flash_enable;
  logic              cfg_write;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  res_t          res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_capacity  <= '0;
      flash_capacity <= '0;
      flash_enable   <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_FAST_CAP:  fast_capacity  <= pwdata[SLOT_W-1:0];
        REG_FLASH_CAP: flash_capacity <= pwdata[SLOT_W-1:0];
        REG_FLASH_EN:  flash_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FAST_CAP:  prdata = {16'h0, fast_capacity};
      REG_FLASH_CAP: prdata = {16'h0, flash_capacity};
      REG_FLASH_EN:  prdata = {31'h0, flash_enable};
      default:       prdata = '0;
    endcase
  end

  pdp_front #(
    .MAX_PAGES (MAX_PAGES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .canon    (s_tdata[CANON_W-1:0]),
    .last     (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  pdp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .data_out (q_out)
  );

  pdp_back #(
    .MAX_PAGES (MAX_PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .fast_cap  (fast_capacity),
    .flash_cap (flash_capacity),
    .flash_en  (flash_enable),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.flash_total, res.fast_total, res.duplicate_total,
                    res.unique_total, res.status, res.slot, res.kind};
  assign m_tlast = res.done;

endmodule

`default_nettype wire

### test/tb_page_dedup_placement_planner_top.sv
// testbench for page_dedup_placement_planner_top: drives page streams and config writes,
// predicts every placement result and checks all its fields; depends on pdp_pkg
`timescale 1ns / 100ps

module tb_page_dedup_placement_planner_top;
  import pdp_pkg::*;

  localparam int MAX_PAGES  = 1024;
  localparam int QUIET_MAX  = 2000;
  localparam int HOLD_LEN   = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  // canonical_index [9:0], zeros [15:10]
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  // page_kind [1:0], page_slot [17:2], plan_status [19:18], unique_total [30:20],
  // duplicate_total [41:31], fast_total [52:42], flash_total [63:53]
  wire  [63:0] m_tdata;
  wire         m_tlast;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  page_dedup_placement_planner_top #(.MAX_PAGES(MAX_PAGES)) u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // planner copy: config and per-plan state
  logic [15:0] cfg_fast_cap = '0;
  logic [15:0] cfg_flash_cap = '0;
  logic        cfg_flash_en = 1'b0;
  int          page_idx = 0;
  int          fast_used = 0;
  int          flash_used = 0;
  int          dup_used = 0;
  logic [1:0]  plan_err = ST_OK;
  logic [1:0]  tbl_kind [MAX_PAGES];
  logic [15:0] tbl_slot [MAX_PAGES];
  logic        tbl_self [MAX_PAGES];

  res_t placement_q[$];
  int   mismatches = 0;
  int   pages_sent = 0;
  int   quiet_cycles = 0;
  bit   src_idle_on = 1'b1;
  logic snk_idle_on = 1'b1;
  logic hold_sink = 1'b0;
  int   stall_left = 0;

  function automatic res_t plan_page(input logic [9:0] canon, input logic last);
    res_t r;
    int   c;
    logic [1:0]  kind;
    logic [15:0] slot;
    c = int'(canon);
    kind = KIND_NONE;
    slot = '0;
    if (plan_err == ST_OK) begin
      if (page_idx >= MAX_PAGES || c > page_idx) begin
        plan_err = ST_BAD_MAP;
      end else if (c == page_idx) begin
        if (fast_used < cfg_fast_cap) begin
          kind = KIND_FAST;
          slot = SLOT_W'(fast_used);
          fast_used++;
        end else if (cfg_flash_en && flash_used < cfg_flash_cap) begin
          kind = KIND_FLASH;
          slot = SLOT_W'(flash_used);
          flash_used++;
        end else begin
          plan_err = ST_NO_SPACE;
        end
        if (plan_err == ST_OK) begin
          tbl_self[page_idx] = 1'b1;
          tbl_kind[page_idx] = kind;
          tbl_slot[page_idx] = slot;
        end
      end else begin
        // canonical must itself be a placed unique page
        if (!tbl_self[c] || tbl_kind[c] == KIND_NONE) begin
          plan_err = ST_BAD_MAP;
        end else begin
          kind = tbl_kind[c];
          slot = tbl_slot[c];
          dup_used++;
          tbl_self[page_idx] = 1'b0;
          tbl_kind[page_idx] = kind;
          tbl_slot[page_idx] = slot;
        end
      end
    end
    r.kind            = kind;
    r.slot            = slot;
    r.status          = plan_err;
    r.unique_total    = TOTAL_W'(fast_used + flash_used);
    r.duplicate_total = TOTAL_W'(dup_used);
    r.fast_total      = TOTAL_W'(fast_used);
    r.flash_total     = TOTAL_W'(flash_used);
    r.done            = last;
    if (last) begin
      page_idx = 0;
      fast_used = 0;
      flash_used = 0;
      dup_used = 0;
      plan_err = ST_OK;
    end else if (page_idx < MAX_PAGES) begin
      page_idx++;
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check each accepted item, then choose next tready
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind            = m_tdata[1:0];
        got.slot            = m_tdata[17:2];
        got.status          = m_tdata[19:18];
        got.unique_total    = m_tdata[30:20];
        got.duplicate_total = m_tdata[41:31];
        got.fast_total      = m_tdata[52:42];
        got.flash_total     = m_tdata[63:53];
        got.done            = m_tlast;
        if (placement_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: %h last %b", m_tdata, m_tlast);
        end else begin
          want = placement_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch exp: kind %0d slot %0d st %0d uniq %0d",
                        " dup %0d fast %0d flash %0d done %0d"},
                       want.kind, want.slot, want.status, want.unique_total,
                       want.duplicate_total, want.fast_total, want.flash_total, want.done);
              $display({"         got: kind %0d slot %0d st %0d uniq %0d",
                        " dup %0d fast %0d flash %0d done %0d"},
                       got.kind, got.slot, got.status, got.unique_total,
                       got.duplicate_total, got.fast_total, got.flash_total, got.done);
            end
          end
        end
      end
      if (hold_sink) begin
        m_tready <= 1'b0;
      end else if (!snk_idle_on) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted item anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_page(input logic [9:0] canon, input logic last);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {6'b0, canon};
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    placement_q.push_back(plan_page(canon, last));
    pages_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FAST_CAP:  cfg_fast_cap = value[15:0];
      REG_FLASH_CAP: cfg_flash_cap = value[15:0];
      REG_FLASH_EN:  cfg_flash_en = value[0];
      default: ;
    endcase
  endtask

  task automatic set_caps(input int fast_cap, input int flash_cap, input bit flash_en);
    wait_idle();
    write_reg(REG_FAST_CAP, fast_cap);
    write_reg(REG_FLASH_CAP, flash_cap);
    write_reg(REG_FLASH_EN, 32'(flash_en));
  endtask

  // mostly well-formed plan: uniques and duplicates of earlier uniques, some duplicates of duplicates and noise
  task automatic send_random_plan(input int len, input int noise_pct);
    int uniq_q[$];
    int dup_q[$];
    int roll;
    logic [9:0] canon;
    for (int p = 0; p < len; p++) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct)
        canon = 10'($urandom_range(0, 1023));
      else if (roll < noise_pct + 4 && dup_q.size() > 0)
        canon = 10'(dup_q[$urandom_range(0, dup_q.size() - 1)]);
      else if (uniq_q.size() == 0 || roll >= 60)
        canon = 10'(p);
      else
        canon = 10'(uniq_q[$urandom_range(0, uniq_q.size() - 1)]);
      if (canon == p) uniq_q.push_back(p);
      else if (canon < p) dup_q.push_back(p);
      send_page(canon, p == len - 1);
    end
  endtask

  task automatic test_basic_placement();
    set_caps(2, 2, 1'b1);
    send_page(0, 0);   // fast 0
    send_page(1, 0);   // fast 1
    send_page(0, 0);
    send_page(3, 0);   // fast full, flash 0
    send_page(1, 0);
    send_page(5, 0);   // flash 1
    send_page(3, 0);
    send_page(7, 0);   // both full
    send_page(0, 1);
  endtask

  task automatic test_bad_mapping();
    send_page(1023, 1);  // canonical ahead on first page
    send_page(0, 0);
    send_page(0, 0);
    send_page(1, 0);     // duplicate of a duplicate
    send_page(0, 1);
    send_page(0, 0);
    send_page(2, 1);     // canonical ahead
  endtask

  task automatic test_flash_limits();
    set_caps(1, 65535, 1'b0);
    send_page(0, 0);
    send_page(1, 1);     // flash disabled, no space
    set_caps(0, 65535, 1'b1);
    send_page(0, 0);
    send_page(0, 0);
    send_page(2, 1);
    set_caps(0, 0, 1'b1);
    send_page(0, 1);
  endtask

  task automatic test_back_pressure();
    set_caps(65535, 0, 1'b0);
    src_idle_on = 1'b0;
    fork
      begin
        hold_sink <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_sink <= 1'b0;
      end
    join_none
    send_random_plan(80, 5);
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_plans();
    int start;
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_caps(65535, 65535, 1'b1);
        5: set_caps(0, $urandom_range(0, 12), 1'b1);
        default: set_caps($urandom_range(0, 12), $urandom_range(0, 12),
                          1'($urandom_range(0, 1)));
      endcase
      src_idle_on = (phase != 2);
      snk_idle_on <= (phase != 2);
      start = pages_sent;
      while (pages_sent - start < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        send_random_plan(len, 8);
      end
    end
    src_idle_on = 1'b1;
    snk_idle_on <= 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_placement();
    test_bad_mapping();
    test_flash_limits();
    test_back_pressure();
    test_random_plans();
    wait_idle();
    if (mismatches == 0 && placement_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
